>>> src/sks_pkg.sv
// Shared types, codes and constants of the station-keeping speed and steering unit.
// Used by the front end, the item queue and the back end pipeline.
`default_nettype none
package sks_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTRW  = 2;
   localparam int XW     = 36;
   localparam int ZW     = 18;
   localparam int RW     = 27;
   localparam int DIVQ   = 16;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_ERR   = 2'd2;

   localparam logic KIND_START = 1'b0;

   localparam logic [2:0] REG_MIN_RADIUS    = 3'd0;
   localparam logic [2:0] REG_MAX_RADIUS    = 3'd1;
   localparam logic [2:0] REG_MIN_SPEED     = 3'd2;
   localparam logic [2:0] REG_MAX_SPEED     = 3'd3;
   localparam logic [2:0] REG_MAX_TURN_RATE = 3'd4;

   localparam logic [15:0] RST_MIN_RADIUS    = 16'd512;
   localparam logic [15:0] RST_MAX_RADIUS    = 16'd2560;
   localparam logic [15:0] RST_MIN_SPEED     = 16'd0;
   localparam logic [15:0] RST_MAX_SPEED     = 16'd512;
   localparam logic [15:0] RST_MAX_TURN_RATE = 16'd512;

   localparam logic [15:0] RANGE_GAIN = 16'd39797;

   typedef enum logic [1:0] {BAND_FULL, BAND_LIN, BAND_NEG, BAND_ZERO} band_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic signed [15:0] heading;
      logic [15:0]        rmin;
      logic [15:0]        rmax;
      logic [15:0]        vmax;
   } item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] heading;
      logic [15:0]        rmin;
      logic [15:0]        rmax;
      logic [15:0]        vmax;
      logic               zero_off;
      logic [16:0]        ae;
      logic               e_neg;
      logic signed [16:0] turn;
      logic               gt_min;
      band_type           band;
   } ctx_type;

   // Arctangent of 2^-i in binary-angle units, rounded.
   function automatic logic signed [ZW-1:0] atan_step(input int idx);
      logic signed [ZW-1:0] r;
      unique case (idx)
         0:  r = 18'sd8192;
         1:  r = 18'sd4836;
         2:  r = 18'sd2555;
         3:  r = 18'sd1297;
         4:  r = 18'sd651;
         5:  r = 18'sd326;
         6:  r = 18'sd163;
         7:  r = 18'sd81;
         8:  r = 18'sd41;
         9:  r = 18'sd20;
         10: r = 18'sd10;
         11: r = 18'sd5;
         12: r = 18'sd3;
         13: r = 18'sd1;
         14: r = 18'sd1;
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/sks_front.sv
// Front end: configuration registers, start handling and target offset per item.
// Depends on sks_pkg; feeds sks_queue.
`default_nettype none
module sks_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_kind,
   input  wire logic               req_pose_valid,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [15:0] req_heading,
   input  wire logic [15:0]        req_goal_min_radius,
   input  wire logic [15:0]        req_goal_max_radius,
   input  wire logic [15:0]        req_goal_max_speed,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic               q_full,
   output      logic               q_push,
   output      sks_pkg::item_type  q_item,
   output      logic [15:0]        min_speed,
   output      logic [15:0]        max_turn_rate
);
   import sks_pkg::*;

   logic [15:0] min_radius_ff, max_radius_ff, min_speed_ff, max_speed_ff, max_turn_rate_ff;
   logic signed [23:0] target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [15:0] act_min_ff, act_min_in, act_max_ff, act_max_in, act_spd_ff, act_spd_in;
   logic accept, is_start;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_start  = (req_kind == KIND_START);
   assign q_push    = accept;
   assign min_speed = min_speed_ff;
   assign max_turn_rate = max_turn_rate_ff;

   always_comb begin
      target_x_in = target_x_ff;
      target_y_in = target_y_ff;
      act_min_in  = act_min_ff;
      act_max_in  = act_max_ff;
      act_spd_in  = act_spd_ff;
      if (accept && is_start) begin
         act_min_in = (req_goal_min_radius != 16'd0) ? req_goal_min_radius : min_radius_ff;
         act_max_in = (req_goal_max_radius != 16'd0) ? req_goal_max_radius : max_radius_ff;
         act_spd_in = (req_goal_max_speed != 16'd0) ? req_goal_max_speed : max_speed_ff;
         if (req_pose_valid) begin
            target_x_in = req_pos_x;
            target_y_in = req_pos_y;
         end
      end
   end

   always_comb begin
      q_item.dx      = 25'(target_x_ff) - 25'(req_pos_x);
      q_item.dy      = 25'(target_y_ff) - 25'(req_pos_y);
      q_item.heading = req_heading;
      q_item.rmin    = act_min_ff;
      q_item.rmax    = act_max_ff;
      q_item.vmax    = act_spd_ff;
      if (!req_pose_valid) begin
         q_item.status = ST_ERR;
      end else if (is_start) begin
         q_item.status = ST_START;
      end else begin
         q_item.status = ST_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_radius_ff    <= RST_MIN_RADIUS;
         max_radius_ff    <= RST_MAX_RADIUS;
         min_speed_ff     <= RST_MIN_SPEED;
         max_speed_ff     <= RST_MAX_SPEED;
         max_turn_rate_ff <= RST_MAX_TURN_RATE;
         target_x_ff      <= '0;
         target_y_ff      <= '0;
         act_min_ff       <= RST_MIN_RADIUS;
         act_max_ff       <= RST_MAX_RADIUS;
         act_spd_ff       <= RST_MAX_SPEED;
      end else begin
         target_x_ff <= target_x_in;
         target_y_ff <= target_y_in;
         act_min_ff  <= act_min_in;
         act_max_ff  <= act_max_in;
         act_spd_ff  <= act_spd_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_MIN_RADIUS:    min_radius_ff    <= csr_wdata;
               REG_MAX_RADIUS:    max_radius_ff    <= csr_wdata;
               REG_MIN_SPEED:     min_speed_ff     <= csr_wdata;
               REG_MAX_SPEED:     max_speed_ff     <= csr_wdata;
               REG_MAX_TURN_RATE: max_turn_rate_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

>>> src/sks_queue.sv
// Short item queue between the front end and the back end pipeline.
// Depends on sks_pkg for the item type and depth.
`default_nettype none
module sks_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sks_pkg::item_type push_item,
   output      logic              full,
   input  wire logic              pop,
   output      logic              avail,
   output      sks_pkg::item_type pop_item
);
   import sks_pkg::*;

   item_type         slot_ff [QDEPTH];
   logic [QPTRW-1:0] wr_ff, rd_ff;
   logic [QPTRW:0]   cnt_ff;
   logic             do_pop;

   assign full     = (cnt_ff == (QPTRW+1)'(QDEPTH));
   assign avail    = (cnt_ff != '0);
   assign do_pop   = pop && avail;
   assign pop_item = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (QPTRW+1)'(push) - (QPTRW+1)'(do_pop);
      end
   end
endmodule
`default_nettype wire

>>> src/sks_back.sv
// Back end pipeline: CORDIC range and bearing, turn rate, speed bands with a
// pipelined divider, steering scale and speed floor. Depends on sks_pkg.
`default_nettype none
module sks_back #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_avail,
   input  wire sks_pkg::item_type  q_item,
   output      logic               q_pop,
   input  wire logic [15:0]        min_speed,
   input  wire logic [15:0]        max_turn_rate,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [1:0]         rsp_status,
   output      logic signed [16:0] rsp_turn_rate,
   output      logic signed [16:0] rsp_forward_speed
);
   import sks_pkg::*;

   logic adv;

   // CORDIC stages: index 0 holds the pre-rotated vector.
   logic                 c_vld_ff [CORDIC_STEPS+1];
   logic signed [XW-1:0] cx_ff    [CORDIC_STEPS+1];
   logic signed [XW-1:0] cy_ff    [CORDIC_STEPS+1];
   logic signed [ZW-1:0] cz_ff    [CORDIC_STEPS+1];
   ctx_type              cctx_ff  [CORDIC_STEPS+1];

   logic signed [XW-1:0] x0_in, y0_in, ax, ay;
   logic signed [ZW-1:0] z0_in;
   ctx_type              ctx0_in;

   logic                 s1_vld_ff;
   logic [33:0]          s1_plo_ff;
   logic signed [34:0]   s1_phi_ff;
   logic [32:0]          s1_tprod_ff;
   ctx_type              s1_ctx_ff, s1_ctx_in;
   logic signed [XW-1:0] xf;
   logic signed [ZW-1:0] zf;
   logic signed [15:0]   e16;

   logic                 s2_vld_ff;
   logic [RW-1:0]        s2_range_ff, s2_range_in;
   ctx_type              s2_ctx_ff, s2_ctx_in;
   logic signed [53:0]   rsum;
   logic [32:0]          tsum;
   logic [16:0]          tmag;

   // Divider stages: index 0 is loaded from the band selection.
   logic                 d_vld_ff [DIVQ+1];
   logic [19:0]          d_rem_ff [DIVQ+1];
   logic [15:0]          d_low_ff [DIVQ+1];
   logic [15:0]          d_q_ff   [DIVQ+1];
   logic [19:0]          d_div_ff [DIVQ+1];
   ctx_type              d_ctx_ff [DIVQ+1];

   logic                 ge_max, gt_min, lt_half;
   logic [15:0]          r16, mul_a;
   logic [19:0]          div_in;
   logic [31:0]          num;
   ctx_type              s3_ctx_in;

   logic                 s4_vld_ff;
   logic [29:0]          s4_prod_ff, s4_prod_in;
   ctx_type              s4_ctx_ff;
   logic [15:0]          mag;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic signed [16:0]   rsp_turn_ff, rsp_turn_in, rsp_speed_ff, rsp_speed_in;
   logic [15:0]          m16;

   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv;

   // Vectors in the left half-plane are turned by a quarter turn first.
   always_comb begin
      ax = XW'(q_item.dx) <<< 8;
      ay = XW'(q_item.dy) <<< 8;
      x0_in = ax;
      y0_in = ay;
      z0_in = '0;
      if (ax < 0) begin
         if (ay >= 0) begin
            x0_in = ay;
            y0_in = -ax;
            z0_in = 18'sd16384;
         end else begin
            x0_in = -ay;
            y0_in = ax;
            z0_in = -18'sd16384;
         end
      end
      ctx0_in          = '0;
      ctx0_in.status   = q_item.status;
      ctx0_in.heading  = q_item.heading;
      ctx0_in.rmin     = q_item.rmin;
      ctx0_in.rmax     = q_item.rmax;
      ctx0_in.vmax     = q_item.vmax;
      ctx0_in.zero_off = (q_item.dx == '0) && (q_item.dy == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]   <= x0_in;
         cy_ff[0]   <= y0_in;
         cz_ff[0]   <= z0_in;
         cctx_ff[0] <= ctx0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         c_vld_ff[0] <= q_avail;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) begin
            cctx_ff[i+1] <= cctx_ff[i];
            if (cy_ff[i] >= 0) begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + atan_step(i);
            end else begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - atan_step(i);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            c_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            c_vld_ff[i+1] <= c_vld_ff[i];
         end
      end
   end

   // Range gain multiply split in two halves; steering error and turn product.
   always_comb begin
      xf = cx_ff[CORDIC_STEPS];
      zf = cctx_ff[CORDIC_STEPS].zero_off ? '0 : cz_ff[CORDIC_STEPS];
      e16 = zf[15:0] - cctx_ff[CORDIC_STEPS].heading;
      s1_ctx_in       = cctx_ff[CORDIC_STEPS];
      s1_ctx_in.e_neg = e16[15];
      s1_ctx_in.ae    = e16[15] ? (17'd0 - 17'(e16)) : 17'(e16);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_plo_ff   <= 34'(xf[17:0]) * 34'(RANGE_GAIN);
         s1_phi_ff   <= 35'(xf[XW-1:18]) * $signed({19'd0, RANGE_GAIN});
         s1_tprod_ff <= 33'(s1_ctx_in.ae) * 33'(max_turn_rate);
         s1_ctx_ff   <= s1_ctx_in;
      end
   end

   always_comb begin
      rsum = (54'(s1_phi_ff) <<< 18) + $signed(54'(s1_plo_ff)) + 54'sd8388608;
      s2_range_in = rsum[53] ? '0 : rsum[RW+23:24];
      tsum = s1_tprod_ff + 33'd16384;
      tmag = tsum[31:15];
      s2_ctx_in = s1_ctx_ff;
      s2_ctx_in.turn = s1_ctx_ff.e_neg ? -$signed(tmag) : $signed(tmag);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_range_ff <= s2_range_in;
         s2_ctx_ff   <= s2_ctx_in;
      end
   end

   // Band selection; the divisor is nonzero whenever a divide band is chosen.
   always_comb begin
      ge_max  = s2_range_ff >= RW'(s2_ctx_ff.rmax);
      gt_min  = s2_range_ff > RW'(s2_ctx_ff.rmin);
      lt_half = {s2_range_ff, 1'b0} < (RW+1)'(s2_ctx_ff.rmin);
      r16     = s2_range_ff[15:0];
      s3_ctx_in        = s2_ctx_ff;
      s3_ctx_in.gt_min = gt_min;
      mul_a  = '0;
      div_in = '0;
      priority if (ge_max) begin
         s3_ctx_in.band = BAND_FULL;
      end else if (gt_min) begin
         s3_ctx_in.band = BAND_LIN;
         mul_a  = r16 - s2_ctx_ff.rmin;
         div_in = 20'(s2_ctx_ff.rmax - s2_ctx_ff.rmin);
      end else if (lt_half) begin
         s3_ctx_in.band = BAND_NEG;
         mul_a  = s2_ctx_ff.rmin - r16;
         div_in = (20'(s2_ctx_ff.rmin) << 3) + (20'(s2_ctx_ff.rmin) << 1);
      end else begin
         s3_ctx_in.band = BAND_ZERO;
      end
      num = 32'(mul_a) * 32'(s2_ctx_ff.vmax);
   end

   // The quotient fits in 16 bits, so the upper numerator half starts as remainder.
   always_ff @(posedge clock) begin
      if (adv) begin
         d_rem_ff[0] <= {4'd0, num[31:16]};
         d_low_ff[0] <= num[15:0];
         d_q_ff[0]   <= '0;
         d_div_ff[0] <= div_in;
         d_ctx_ff[0] <= s3_ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         d_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff   <= c_vld_ff[CORDIC_STEPS];
         s2_vld_ff   <= s1_vld_ff;
         d_vld_ff[0] <= s2_vld_ff;
      end
   end

   for (genvar k = 0; k < DIVQ; k++) begin : g_div
      logic [20:0] t;
      logic        ge;
      assign t  = {d_rem_ff[k], d_low_ff[k][15]};
      assign ge = t >= {1'b0, d_div_ff[k]};
      always_ff @(posedge clock) begin
         if (adv) begin
            d_rem_ff[k+1] <= ge ? 20'(t - {1'b0, d_div_ff[k]}) : t[19:0];
            d_low_ff[k+1] <= {d_low_ff[k][14:0], 1'b0};
            d_q_ff[k+1]   <= {d_q_ff[k][14:0], ge};
            d_div_ff[k+1] <= d_div_ff[k];
            d_ctx_ff[k+1] <= d_ctx_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            d_vld_ff[k+1] <= d_vld_ff[k];
         end
      end
   end

   // Steering share: zero above a quarter of pi, else scale by (8192-|e|)/8192.
   always_comb begin
      unique case (d_ctx_ff[DIVQ].band)
         BAND_FULL: mag = d_ctx_ff[DIVQ].vmax;
         BAND_LIN,
         BAND_NEG:  mag = d_q_ff[DIVQ];
         default:   mag = '0;
      endcase
      if (d_ctx_ff[DIVQ].ae > 17'd8192) begin
         s4_prod_in = '0;
      end else begin
         s4_prod_in = 30'(mag) * 30'(14'(17'd8192 - d_ctx_ff[DIVQ].ae));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_prod_ff <= s4_prod_in;
         s4_ctx_ff  <= d_ctx_ff[DIVQ];
      end
   end

   always_comb begin
      m16 = s4_prod_ff[28:13];
      rsp_status_in = s4_ctx_ff.status;
      rsp_turn_in   = s4_ctx_ff.turn;
      if (s4_ctx_ff.band == BAND_NEG) begin
         rsp_speed_in = -$signed({1'b0, m16});
      end else begin
         rsp_speed_in = $signed({1'b0, m16});
      end
      if (s4_ctx_ff.gt_min && (m16 < min_speed)) begin
         rsp_speed_in = $signed({1'b0, min_speed});
      end
      if (s4_ctx_ff.status != ST_RUN) begin
         rsp_turn_in  = '0;
         rsp_speed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_status_ff <= rsp_status_in;
         rsp_turn_ff   <= rsp_turn_in;
         rsp_speed_ff  <= rsp_speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff    <= d_vld_ff[DIVQ];
         rsp_valid_ff <= s4_vld_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_turn_rate     = rsp_turn_ff;
   assign rsp_forward_speed = rsp_speed_ff;
endmodule
`default_nettype wire

>>> src/station_keeping_speed_steer_unit.sv
// Station-keeping speed and steering unit.
// Items arrive on the req_ channel (valid/stall); a start item latches the
// active radii and full speed, and the target if its pose is valid; a tick
// item yields a turn rate and forward speed. Every item gives exactly one
// beat on the rsp_ channel, in order. The user must write the registers via
// csr_we/csr_index/csr_wdata only while the unit is idle; the block itself
// does not enforce this. Throughput: one item per cycle while no result is
// held by rsp_stall. The back end is a pipeline: one pre-rotation stage,
// CORDIC_STEPS CORDIC stages, three stages for range, turn rate and band
// selection, sixteen divider stages, one scaling stage and the output
// register.
// When rsp_stall holds a result, the whole back end freezes; the four-entry
// queue keeps taking items until it fills, then req_stall rises.
// Reset is synchronous: registers return to their defaults, the target goes
// to the origin and the queue and pipeline empty.
`default_nettype none
module station_keeping_speed_steer_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_kind,
   input  wire logic               req_pose_valid,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [15:0] req_heading,
   input  wire logic [15:0]        req_goal_min_radius,
   input  wire logic [15:0]        req_goal_max_radius,
   input  wire logic [15:0]        req_goal_max_speed,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [1:0]         rsp_status,
   output      logic signed [16:0] rsp_turn_rate,
   output      logic signed [16:0] rsp_forward_speed,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import sks_pkg::*;

   logic        q_full, q_push, q_avail, q_pop;
   item_type    q_in_item, q_out_item;
   logic [15:0] min_speed, max_turn_rate;

   sks_front u_front (
      .clock, .reset,
      .req_valid, .req_stall, .req_kind, .req_pose_valid,
      .req_pos_x, .req_pos_y, .req_heading,
      .req_goal_min_radius, .req_goal_max_radius, .req_goal_max_speed,
      .csr_we, .csr_index, .csr_wdata,
      .q_full, .q_push, .q_item(q_in_item),
      .min_speed, .max_turn_rate
   );

   sks_queue u_queue (
      .clock, .reset,
      .push(q_push), .push_item(q_in_item), .full(q_full),
      .pop(q_pop), .avail(q_avail), .pop_item(q_out_item)
   );

   sks_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset,
      .q_avail, .q_item(q_out_item), .q_pop,
      .min_speed, .max_turn_rate,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_turn_rate, .rsp_forward_speed
   );
endmodule
`default_nettype wire

>>> bench/station_keeping_speed_steer_unit_tb.sv
// Testbench for the station-keeping speed and steering unit.
// Depends on sks_pkg and station_keeping_speed_steer_unit; predicts every
// response beat with its own integer model and checks them in order.
`default_nettype none
module station_keeping_speed_steer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sks_pkg::*;

   typedef struct {
      logic [1:0]         status;
      logic signed [16:0] turn;
      logic signed [16:0] speed;
   } steer_cmd_type;

   class steer_scoreboard;
      steer_cmd_type pending[$];
      int errors = 0;
      int checked = 0;
      int unsigned reg_min_radius, reg_max_radius, reg_min_speed, reg_max_speed;
      int unsigned reg_max_turn;
      longint tgt_x, tgt_y;
      int unsigned act_rmin, act_rmax, act_vmax;

      function void clear();
         reg_min_radius = RST_MIN_RADIUS; reg_max_radius = RST_MAX_RADIUS;
         reg_min_speed = RST_MIN_SPEED; reg_max_speed = RST_MAX_SPEED;
         reg_max_turn = RST_MAX_TURN_RATE;
         tgt_x = 0; tgt_y = 0;
         act_rmin = RST_MIN_RADIUS; act_rmax = RST_MAX_RADIUS;
         act_vmax = RST_MAX_SPEED;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            REG_MIN_RADIUS:    reg_min_radius = val;
            REG_MAX_RADIUS:    reg_max_radius = val;
            REG_MIN_SPEED:     reg_min_speed = val;
            REG_MAX_SPEED:     reg_max_speed = val;
            REG_MAX_TURN_RATE: reg_max_turn = val;
            default: ;
         endcase
      endfunction

      static function longint shr(longint v, int s);
         return v >>> s;
      endfunction

      function void note_item(logic kind, logic pv, logic signed [23:0] px,
                              logic signed [23:0] py, logic signed [15:0] hd,
                              logic [15:0] gmin, logic [15:0] gmax, logic [15:0] gspd);
         steer_cmd_type c;
         longint dx, dy, x, y, z, t, xs, ys, rng, e, ae, tmag, rmin, rmax, vmax, v, mag;
         c.status = ST_RUN; c.turn = 0; c.speed = 0;
         if (kind == KIND_START) begin
            act_rmin = (gmin != 0) ? gmin : reg_min_radius;
            act_rmax = (gmax != 0) ? gmax : reg_max_radius;
            act_vmax = (gspd != 0) ? gspd : reg_max_speed;
            if (!pv) c.status = ST_ERR;
            else begin
               tgt_x = px; tgt_y = py; c.status = ST_START;
            end
         end else if (!pv) begin
            c.status = ST_ERR;
         end else begin
            dx = tgt_x - longint'(px); dy = tgt_y - longint'(py);
            x = dx * 256; y = dy * 256; z = 0;
            if (x < 0) begin
               t = x;
               if (y >= 0) begin x = y; y = -t; z = 16384; end
               else begin x = -y; y = t; z = -16384; end
            end
            for (int i = 0; i < 16; i++) begin
               xs = shr(x, i); ys = shr(y, i);
               if (y >= 0) begin x += ys; y -= xs; z += longint'(atan_step(i)); end
               else begin x -= ys; y += xs; z -= longint'(atan_step(i)); end
            end
            if (dx == 0 && dy == 0) z = 0;
            rng = shr(x * 39797 + (longint'(1) << 23), 24);
            if (rng < 0) rng = 0;
            e = ((z - longint'(hd) + 32768) & 64'hFFFF) - 32768;
            ae = (e < 0) ? -e : e;
            tmag = (ae * reg_max_turn + 16384) >>> 15;
            c.turn = (e < 0) ? -tmag : tmag;
            rmin = act_rmin; rmax = act_rmax; vmax = act_vmax;
            if (rng >= rmax) v = vmax;
            else if (rng > rmin) v = (rng - rmin) * vmax / (rmax - rmin);
            else if (2 * rng < rmin) v = -((rmin - rng) * vmax / (10 * rmin));
            else v = 0;
            if (ae > 8192) v = 0;
            else begin
               mag = (v < 0) ? -v : v;
               mag = mag * (8192 - ae) / 8192;
               v = (v < 0) ? -mag : mag;
            end
            if (rng > rmin && v < longint'(reg_min_speed)) v = reg_min_speed;
            c.speed = v;
         end
         pending = {pending, c};
      endfunction

      function void check_beat(logic [1:0] st, logic signed [16:0] tr,
                               logic signed [16:0] fs);
         steer_cmd_type c;
         if (pending.size() == 0) begin
            $error("unexpected response beat status=%0d", st);
            errors++;
            return;
         end
         c = pending.pop_front();
         checked++;
         if (st !== c.status) begin
            $error("status: expected %0d actual %0d", c.status, st); errors++;
         end
         if (tr !== c.turn) begin
            $error("turn_rate: expected %0d actual %0d", c.turn, tr); errors++;
         end
         if (fs !== c.speed) begin
            $error("forward_speed: expected %0d actual %0d", c.speed, fs); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_kind = 0, req_pose_valid = 0;
   logic signed [23:0] req_pos_x = 0, req_pos_y = 0;
   logic signed [15:0] req_heading = 0;
   logic [15:0] req_goal_min_radius = 0, req_goal_max_radius = 0, req_goal_max_speed = 0;
   logic req_stall, rsp_valid, rsp_stall = 0;
   logic [1:0] rsp_status;
   logic signed [16:0] rsp_turn_rate, rsp_forward_speed;
   logic csr_we = 0;
   logic [2:0] csr_index = 0;
   logic [15:0] csr_wdata = 0;

   station_keeping_speed_steer_unit uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   steer_scoreboard sb = new();
   bit quiet_stall = 0;   // a stretch where the receiver never stalls
   int idle_cycles = 0;
   int items_sent = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_beat(rsp_status, rsp_turn_rate,
                                                     rsp_forward_speed);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 2000) begin
            $display("station_keeping_speed_steer_unit_tb: errors");
            $finish;
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= !reset && !quiet_stall && ($urandom_range(99) < 19);

   // Valid stays high after a beat so the next item can follow at once;
   // it drops only while the sender idles or the stream is drained.
   task automatic send_item(logic kind, logic pv, logic signed [23:0] px,
                            logic signed [23:0] py, logic signed [15:0] hd,
                            logic [15:0] gmin, logic [15:0] gmax, logic [15:0] gspd,
                            bit may_idle);
      while (may_idle && $urandom_range(99) < 19) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_kind <= kind; req_pose_valid <= pv;
      req_pos_x <= px; req_pos_y <= py; req_heading <= hd;
      req_goal_min_radius <= gmin; req_goal_max_radius <= gmax;
      req_goal_max_speed <= gspd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(kind, pv, px, py, hd, gmin, gmax, gspd);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      sb.write_reg(idx, val);
   endtask

   function automatic logic [15:0] rand_radius();
      case ($urandom_range(3))
         0: return 16'($urandom_range(65535));
         1: return 16'($urandom_range(8000));
         default: return 16'($urandom_range(3000));
      endcase
   endfunction

   function automatic logic signed [23:0] near(longint c, int spread);
      longint v = c + $urandom_range(2 * spread) - spread;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return 24'(v);
   endfunction

   task automatic random_phase(int count);
      longint cx, cy;
      logic signed [23:0] px, py;
      logic [15:0] gmin, gmax, gspd;
      int spread;
      for (int n = 0; n < count; n++) begin
         if (n == 150) quiet_stall = 1;
         if (n == 250) quiet_stall = 0;
         if (n % 40 == 0 || $urandom_range(99) < 3) begin
            cx = $signed($urandom_range(24'hFFFFFF, 0) ^ 24'h800000) - 8388608;
            cy = $signed($urandom_range(24'hFFFFFF, 0) ^ 24'h800000) - 8388608;
            gmin = ($urandom_range(2) == 0) ? 0 : rand_radius();
            gmax = ($urandom_range(2) == 0) ? 0 : rand_radius();
            gspd = ($urandom_range(2) == 0) ? 0 : 16'($urandom);
            send_item(KIND_START, $urandom_range(9) != 0, near(cx, 0), near(cy, 0),
                      16'($urandom), gmin, gmax, gspd, !quiet_stall);
         end else begin
            case ($urandom_range(3))
               0: spread = 8;
               1: spread = 800;
               2: spread = 6000;
               default: spread = 8388607;
            endcase
            if ($urandom_range(1)) begin
               px = near(sb.tgt_x, spread); py = near(sb.tgt_y, spread);
            end else begin
               px = 24'($urandom); py = 24'($urandom);
            end
            send_item(1'b1, $urandom_range(19) != 0, px, py, 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), !quiet_stall);
         end
      end
   endtask

   initial begin
      sb.clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // Directed: tick before any start, zero offset, error of pi, extremes.
      send_item(1'b1, 1, 0, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, 1000, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, -24'sd8388608, -24'sd8388608, -16'sd32768, 0, 0, 0, 0);
      send_item(1'b1, 1, 24'sd8388607, 24'sd8388607, 16'sd32767, 0, 0, 0, 0);
      send_item(1'b1, 0, 5, 5, 0, 0, 0, 0, 0);
      send_item(KIND_START, 0, 77, 77, 0, 100, 200, 300, 0);
      send_item(KIND_START, 1, 24'sd8388607, -24'sd8388608, 0, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 0);
      send_item(1'b1, 1, -24'sd8388608, 24'sd8388607, 16'sd8192, 0, 0, 0, 0);
      send_item(KIND_START, 1, 0, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, 0, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, -100, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, -3000, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, -1500, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, -200, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, -600, 0, -16'sd8192, 0, 0, 0, 0);
      send_item(1'b1, 1, 0, -700, 16'sd8000, 0, 0, 0, 0);
      send_item(KIND_START, 1, 0, 0, 0, 3000, 100, 0, 0);
      send_item(1'b1, 1, -2000, 0, 0, 0, 0, 0, 0);
      send_item(1'b1, 1, -50, 0, 0, 0, 0, 0, 0);
      drain();
      random_phase(350);
      drain();
      write_reg(REG_MIN_RADIUS, 16'hFFFF);
      write_reg(REG_MAX_RADIUS, 0);
      write_reg(REG_MIN_SPEED, 16'hFFFF);
      write_reg(REG_MAX_SPEED, 16'hFFFF);
      write_reg(REG_MAX_TURN_RATE, 16'hFFFF);
      csr_we <= 0;
      random_phase(350);
      drain();
      write_reg(REG_MIN_RADIUS, 0);
      write_reg(REG_MAX_RADIUS, 16'hFFFF);
      write_reg(REG_MIN_SPEED, 0);
      write_reg(REG_MAX_SPEED, 0);
      write_reg(REG_MAX_TURN_RATE, 0);
      csr_we <= 0;
      random_phase(350);
      drain();
      for (int k = 0; k < 5; k++) write_reg(3'(k), 16'($urandom_range(3000)));
      csr_we <= 0;
      random_phase(380);
      drain();
      $display("Sent %0d items over four register settings; %0d beats checked.",
               items_sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("station_keeping_speed_steer_unit_tb: clean");
      else
         $display("station_keeping_speed_steer_unit_tb: errors");
      $finish;
   end
endmodule
`default_nettype wire
